// ===== rtl/core/aarm_pkg.sv =====
package aarm_pkg;

  // angle reduction constants, radians in Q5.26
  localparam longint TWO_PI_Q26   = 64'sd421657428;
  localparam longint WRAP_OFS     = 64'sd2529944568;  // six turns, lifts any input above zero
  localparam longint HALF_PI_Q26  = 64'sd105414357;
  localparam longint HALF_PI_HALF = 64'sd52707178;
  localparam int     WRAP_TURNS   = 12;
  localparam int     QUAD_STEPS   = 4;

  // Horner coefficients, Q30
  localparam longint ONE_Q30 = 64'sd1073741824;
  localparam longint SIN_K1  = 64'sd178956971;
  localparam longint SIN_K2  = 64'sd8947849;
  localparam longint SIN_K3  = 64'sd213043;
  localparam longint SIN_K4  = 64'sd2959;
  localparam longint COS_K1  = 64'sd536870912;
  localparam longint COS_K2  = 64'sd44739243;
  localparam longint COS_K3  = 64'sd1491308;
  localparam longint COS_K4  = 64'sd26631;
  localparam longint COS_K5  = 64'sd296;

  // output saturation bounds
  localparam longint MAT_MAX = 64'sd131071;
  localparam longint MAT_MIN = -64'sd131072;
  localparam longint VEC_MAX = 64'sd524287;
  localparam longint VEC_MIN = -64'sd524288;

  // shift right by sh, round to nearest, halves away from zero
  function automatic logic signed [65:0] rnd_shift(input logic signed [65:0] p,
                                                    input int unsigned sh);
    logic signed [65:0] half;
    half = 66'sd1 <<< ((sh == 0) ? 0 : sh - 1);
    if (sh == 0) return p;
    if (p < 0) return (p + half - 66'sd1) >>> sh;
    return (p + half) >>> sh;
  endfunction

  // signed product with rounded scaling
  function automatic logic signed [65:0] mul_rnd(input logic signed [32:0] a,
                                                  input logic signed [32:0] b,
                                                  input int unsigned sh);
    logic signed [65:0] p;
    p = a * b;
    return rnd_shift(p, sh);
  endfunction

endpackage

// ===== rtl/core/aarm_sincos.sv =====
module aarm_sincos import aarm_pkg::*; (
  input  logic               clk,
  input  logic signed [31:0] angle,
  output logic signed [31:0] sin_v,
  output logic signed [31:0] cos_v,
  output logic        [28:0] red_angle
);

  logic signed [33:0] u_next;
  logic        [3:0]  k_next;
  logic signed [33:0] u1;
  logic        [3:0]  k1;
  logic        [28:0] r2;
  logic        [2:0]  q_next;
  logic        [33:0] offs;
  logic signed [33:0] diff;
  logic        [28:0] r_p  [3:10];
  logic        [2:0]  q_p  [3:10];
  logic signed [30:0] x_p  [4:9];
  logic signed [30:0] x2_p [5:9];
  logic signed [31:0] t6, t7, t8, t9, s10;
  logic signed [31:0] c6, c7, c8, c9, c10;

  // lift the angle above zero and find the whole turns it holds
  always_comb begin
    u_next = 34'(angle) + 34'(WRAP_OFS);
    k_next = '0;
    for (int k = 1; k < WRAP_TURNS; k++) begin
      if (u_next >= 34'(k) * 34'(TWO_PI_Q26)) k_next = 4'(k);
    end
  end

  // pick the nearest quarter turn
  always_comb begin
    q_next = '0;
    for (int m = 1; m <= QUAD_STEPS; m++) begin
      if (r2 >= 29'(longint'(m) * HALF_PI_Q26 - HALF_PI_HALF)) q_next = 3'(m);
    end
  end

  // residual angle about the quarter turn, scaled to Q30
  always_comb begin
    offs = 34'(q_p[3]) * 34'(HALF_PI_Q26);
    diff = $signed({5'b0, r_p[3]}) - $signed(offs);
  end

  always_ff @(posedge clk) begin
    u1 <= u_next;
    k1 <= k_next;
    r2 <= 29'(u1 - 34'(k1) * 34'(TWO_PI_Q26));
    r_p[3] <= r2;
    q_p[3] <= q_next;
    x_p[4] <= 31'(diff <<< 4);
    for (int i = 4; i <= 10; i++) begin
      r_p[i] <= r_p[i-1];
      q_p[i] <= q_p[i-1];
    end
    for (int i = 5; i <= 9; i++) x_p[i] <= x_p[i-1];
    x2_p[5] <= 31'(mul_rnd(33'(x_p[4]), 33'(x_p[4]), 30));
    for (int i = 6; i <= 9; i++) x2_p[i] <= x2_p[i-1];
    // advance both Horner chains one term a stage
    t6  <= 32'(SIN_K3 - mul_rnd(33'(x2_p[5]), 33'(SIN_K4), 30));
    c6  <= 32'(COS_K4 - mul_rnd(33'(x2_p[5]), 33'(COS_K5), 30));
    t7  <= 32'(SIN_K2 - mul_rnd(33'(x2_p[6]), 33'(t6), 30));
    c7  <= 32'(COS_K3 - mul_rnd(33'(x2_p[6]), 33'(c6), 30));
    t8  <= 32'(SIN_K1 - mul_rnd(33'(x2_p[7]), 33'(t7), 30));
    c8  <= 32'(COS_K2 - mul_rnd(33'(x2_p[7]), 33'(c7), 30));
    t9  <= 32'(ONE_Q30 - mul_rnd(33'(x2_p[8]), 33'(t8), 30));
    c9  <= 32'(COS_K1 - mul_rnd(33'(x2_p[8]), 33'(c8), 30));
    s10 <= 32'(mul_rnd(33'(x_p[9]), 33'(t9), 30));
    c10 <= 32'(ONE_Q30 - mul_rnd(33'(x2_p[9]), 33'(c9), 30));
    // rotate the pair into its quadrant
    unique case (q_p[10][1:0])
      2'd0: begin sin_v <= s10;  cos_v <= c10;  end
      2'd1: begin sin_v <= c10;  cos_v <= -s10; end
      2'd2: begin sin_v <= -s10; cos_v <= -c10; end
      default: begin sin_v <= -c10; cos_v <= s10; end
    endcase
    red_angle <= r_p[10];
  end

endmodule

// ===== rtl/core/axis_angle_to_rotation_matrix.sv =====
// An accepted item's result is registered through the sine/cosine units and then the matrix stages;
// done is high for one cycle, in the cycle in which that result stands on the outputs.
// Throughput: one item per cycle; busy stays low, every stage advances each cycle.
// The depth is set by the eleven-stage sine/cosine polynomial units plus six matrix stages.
// Reset (rst, synchronous) clears the valid bits of all stages; data registers are not reset.
module axis_angle_to_rotation_matrix import aarm_pkg::*; #(
  parameter int OUT_FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic signed [31:0] polar_angle,
  input  logic signed [31:0] azimuth_angle,
  input  logic signed [31:0] rotation_angle,
  output logic               done,
  output logic signed [17:0] m_r0_c0,
  output logic signed [17:0] m_r1_c0,
  output logic signed [17:0] m_r2_c0,
  output logic signed [17:0] m_r0_c1,
  output logic signed [17:0] m_r1_c1,
  output logic signed [17:0] m_r2_c1,
  output logic signed [17:0] m_r0_c2,
  output logic signed [17:0] m_r1_c2,
  output logic signed [17:0] m_r2_c2,
  output logic signed [19:0] rot_vec_x,
  output logic signed [19:0] rot_vec_y,
  output logic signed [19:0] rot_vec_z
);

  localparam int unsigned MSH   = 30 - OUT_FRAC_BITS;
  localparam int unsigned VSH   = 56 - OUT_FRAC_BITS;
  localparam int          DEPTH = 17;

  function automatic logic signed [17:0] sat_mat(input logic signed [65:0] v);
    if (v > 66'(MAT_MAX)) return 18'(MAT_MAX);
    if (v < 66'(MAT_MIN)) return 18'(MAT_MIN);
    return 18'(v);
  endfunction

  function automatic logic signed [19:0] sat_vec(input logic signed [65:0] v);
    if (v > 66'(VEC_MAX)) return 20'(VEC_MAX);
    if (v < 66'(VEC_MIN)) return 20'(VEC_MIN);
    return 20'(v);
  endfunction

  logic               [DEPTH:1] vld;
  logic signed [31:0] th_s, th_c, ph_s, ph_c, an_s, an_c;
  logic        [28:0] an_r;
  logic signed [31:0] w0, w1, w2, sa1;
  logic signed [32:0] omc1, omc2, omc3;
  logic        [28:0] r1;
  logic signed [31:0] p00, p11, p22, p01, p02, p12;
  logic signed [31:0] sw_p [2:4][3];
  logic signed [34:0] vp_p [2:5][3];
  logic signed [32:0] d0, d1, d2;
  logic signed [31:0] k01, k02, k12;
  logic signed [34:0] o00, o11, o22, o01, o02, o12;
  logic signed [35:0] m5 [9];

  assign busy = 1'b0;
  assign done = vld[DEPTH];

  aarm_sincos u_sc_th (.clk, .angle(polar_angle),    .sin_v(th_s), .cos_v(th_c),
                       .red_angle());
  aarm_sincos u_sc_ph (.clk, .angle(azimuth_angle),  .sin_v(ph_s), .cos_v(ph_c),
                       .red_angle());
  aarm_sincos u_sc_an (.clk, .angle(rotation_angle), .sin_v(an_s), .cos_v(an_c),
                       .red_angle(an_r));

  // track which stages hold an item
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[DEPTH-1:1], start & ~busy};
    end
  end

  always_ff @(posedge clk) begin
    // form the unit axis
    w0   <= 32'(mul_rnd(33'(th_s), 33'(ph_c), 30));
    w1   <= 32'(mul_rnd(33'(th_s), 33'(ph_s), 30));
    w2   <= th_c;
    sa1  <= an_s;
    omc1 <= 33'(ONE_Q30) - 33'(an_c);
    r1   <= an_r;
    // axis products, sine terms and vector products
    p00 <= 32'(mul_rnd(33'(w0), 33'(w0), 30));
    p11 <= 32'(mul_rnd(33'(w1), 33'(w1), 30));
    p22 <= 32'(mul_rnd(33'(w2), 33'(w2), 30));
    p01 <= 32'(mul_rnd(33'(w0), 33'(w1), 30));
    p02 <= 32'(mul_rnd(33'(w0), 33'(w2), 30));
    p12 <= 32'(mul_rnd(33'(w1), 33'(w2), 30));
    sw_p[2][0] <= 32'(mul_rnd(33'(sa1), 33'(w0), 30));
    sw_p[2][1] <= 32'(mul_rnd(33'(sa1), 33'(w1), 30));
    sw_p[2][2] <= 32'(mul_rnd(33'(sa1), 33'(w2), 30));
    vp_p[2][0] <= 35'(mul_rnd(33'({4'b0, r1}), 33'(w0), VSH));
    vp_p[2][1] <= 35'(mul_rnd(33'({4'b0, r1}), 33'(w1), VSH));
    vp_p[2][2] <= 35'(mul_rnd(33'({4'b0, r1}), 33'(w2), VSH));
    omc2 <= omc1;
    for (int s = 3; s <= 4; s++) sw_p[s] <= sw_p[s-1];
    for (int s = 3; s <= 5; s++) vp_p[s] <= vp_p[s-1];
    // build K squared
    d0   <= 33'(-(33'(p11) + 33'(p22)));
    d1   <= 33'(-(33'(p22) + 33'(p00)));
    d2   <= 33'(-(33'(p00) + 33'(p11)));
    k01  <= p01;
    k02  <= p02;
    k12  <= p12;
    omc3 <= omc2;
    // scale K squared by one minus cosine
    o00 <= 35'(mul_rnd(omc3, d0, 30));
    o11 <= 35'(mul_rnd(omc3, d1, 30));
    o22 <= 35'(mul_rnd(omc3, d2, 30));
    o01 <= 35'(mul_rnd(omc3, 33'(k01), 30));
    o02 <= 35'(mul_rnd(omc3, 33'(k02), 30));
    o12 <= 35'(mul_rnd(omc3, 33'(k12), 30));
    // sum the matrix, column by column
    m5[0] <= 36'(ONE_Q30) + 36'(o00);
    m5[1] <= 36'(sw_p[4][2]) + 36'(o01);
    m5[2] <= 36'(o02) - 36'(sw_p[4][1]);
    m5[3] <= 36'(o01) - 36'(sw_p[4][2]);
    m5[4] <= 36'(ONE_Q30) + 36'(o11);
    m5[5] <= 36'(sw_p[4][0]) + 36'(o12);
    m5[6] <= 36'(sw_p[4][1]) + 36'(o02);
    m5[7] <= 36'(o12) - 36'(sw_p[4][0]);
    m5[8] <= 36'(ONE_Q30) + 36'(o22);
    // round and saturate into the output registers
    m_r0_c0   <= sat_mat(rnd_shift(66'(m5[0]), MSH));
    m_r1_c0   <= sat_mat(rnd_shift(66'(m5[1]), MSH));
    m_r2_c0   <= sat_mat(rnd_shift(66'(m5[2]), MSH));
    m_r0_c1   <= sat_mat(rnd_shift(66'(m5[3]), MSH));
    m_r1_c1   <= sat_mat(rnd_shift(66'(m5[4]), MSH));
    m_r2_c1   <= sat_mat(rnd_shift(66'(m5[5]), MSH));
    m_r0_c2   <= sat_mat(rnd_shift(66'(m5[6]), MSH));
    m_r1_c2   <= sat_mat(rnd_shift(66'(m5[7]), MSH));
    m_r2_c2   <= sat_mat(rnd_shift(66'(m5[8]), MSH));
    rot_vec_x <= sat_vec(66'(vp_p[5][0]));
    rot_vec_y <= sat_vec(66'(vp_p[5][1]));
    rot_vec_z <= sat_vec(66'(vp_p[5][2]));
  end

  // every accepted item comes out after the full pipeline depth
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##17 done)
    else $error("accepted item did not produce a result");

  // no result without an item accepted the pipeline depth earlier
  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, 17))
    else $error("result strobe without an accepted item");

  // zero rotation gives a zero vector and zero skew entries at r1_c0 and r0_c1
  a_zero_rot: assert property (@(posedge clk) disable iff (rst)
    (done && $past(rotation_angle, 17) == 32'sd0) |->
      (rot_vec_x == 20'sd0 && rot_vec_y == 20'sd0 && rot_vec_z == 20'sd0 &&
       m_r1_c0 == 18'sd0 && m_r0_c1 == 18'sd0))
    else $error("zero rotation gave a nonzero vector or skew entry");

endmodule
